// ===== design/depth_buffer_test_update_defines.svh =====
// ----------------------------------------------------------------------------
// Depth buffer assertion macros
// Concurrent assertion helpers for the depth buffer block; they sample on
// clk and are disabled while arst_n is low. Empty outside simulation.
// ----------------------------------------------------------------------------
`ifndef DEPTH_BUFFER_TEST_UPDATE_DEFINES_SVH
`define DEPTH_BUFFER_TEST_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
`define DBTU_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dbtu assertion failed");
`define DBTU_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dbtu assertion failed");
`else
`define DBTU_ASSERT_SAME(name, ante, cons)
`define DBTU_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== design/dbtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtu_pkg
// Shared types and constants of the depth buffer: beat structs, command
// codes, register indexes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dbtu_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 256;
	localparam int unsigned MAX_HEIGHT_DEF = 256;
	localparam int unsigned DEPTH_BITS_DEF = 24;

	localparam int unsigned CMD_W      = 2;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned DEPTH_W    = 24;
	localparam int unsigned FRAME_W    = 9;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;

	// command 1 and the unused code both act as a read
	localparam logic [CMD_W-1:0] CMD_TEST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic [DEPTH_W-1:0]        depth_in;
	} in_item_t;

	typedef struct packed {
		logic               passed;
		logic               in_frame;
		logic [DEPTH_W-1:0] depth_out;
	} result_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_width;
		logic [FRAME_W-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic read;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

// ===== design/dbtu_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtu_regs
// APB register file holding the frame width and frame height.
// ----------------------------------------------------------------------------
module dbtu_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [dbtu_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [dbtu_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [dbtu_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output dbtu_pkg::cfg_t                       cfg
);

	dbtu_pkg::cfg_t cfg_q;
	logic           reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= dbtu_pkg::FRAME_RESET;
			cfg_q.frame_height <= dbtu_pkg::FRAME_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				dbtu_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[dbtu_pkg::FRAME_W-1:0];
				dbtu_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[dbtu_pkg::FRAME_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dbtu_pkg::REG_FRAME_WIDTH:
				prdata = dbtu_pkg::APB_DATA_W'(cfg_q.frame_width);
			dbtu_pkg::REG_FRAME_HEIGHT:
				prdata = dbtu_pkg::APB_DATA_W'(cfg_q.frame_height);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== design/dbtu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtu_ctrl
// Sequencer: sweeps the store to far depth after reset, then runs each
// command beat through load, read and update.
// ----------------------------------------------------------------------------
module dbtu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dbtu_pkg::dp_status_t status,
	output dbtu_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 result_valid
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			busy_q         <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (status.clear_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
						busy_q  <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q        <= S_IDLE;
					busy_q         <= 1'b0;
					result_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign cmd.clear    = (state_q == S_CLEAR);
	assign cmd.load     = (state_q == S_IDLE) && start;
	assign cmd.read     = (state_q == S_READ);
	assign cmd.update   = (state_q == S_UPDATE);
	assign busy         = busy_q;
	assign result_valid = result_valid_q;

endmodule

// ===== design/dbtu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtu_datapath
// Depth store memory, frame check, address generation, clear sweep counter,
// less-or-equal depth compare and result register.
// ----------------------------------------------------------------------------
module dbtu_datapath #(
	parameter int unsigned MAX_WIDTH  = dbtu_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = dbtu_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned DEPTH_BITS = dbtu_pkg::DEPTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dbtu_pkg::dp_cmd_t    cmd,
	output dbtu_pkg::dp_status_t status,
	input  dbtu_pkg::in_item_t   item,
	input  dbtu_pkg::cfg_t       cfg,
	output dbtu_pkg::result_t    result
);

	localparam int unsigned Store = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AddrW = (Store > 1) ? $clog2(Store) : 1;
	localparam int unsigned CmpW  = dbtu_pkg::COORD_W + 1;
	localparam logic [AddrW-1:0]      Stride   = AddrW'(MAX_WIDTH);
	localparam logic [AddrW-1:0]      LastAddr = AddrW'(Store - 1);
	localparam logic [DEPTH_BITS-1:0] FarDepth = '1;

	logic [DEPTH_BITS-1:0] mem [Store];

	logic [dbtu_pkg::CMD_W-1:0]   command_s1;
	logic [dbtu_pkg::COORD_W-1:0] col_s1;
	logic [dbtu_pkg::COORD_W-1:0] row_s1;
	logic [DEPTH_BITS-1:0]        depth_s1;

	logic [AddrW-1:0]      addr_c;
	logic                  col_ok;
	logic                  row_ok;
	logic                  in_frame_c;
	logic [AddrW-1:0]      addr_s2;
	logic                  in_frame_s2;
	logic [DEPTH_BITS-1:0] stored_s2;

	logic [AddrW-1:0]      clr_q;
	logic                  test_ok;
	logic                  is_write;
	logic                  store_new;
	logic                  wr_en;
	logic [AddrW-1:0]      wr_addr;
	logic [DEPTH_BITS-1:0] wr_data;
	logic [DEPTH_BITS-1:0] depth_after;
	dbtu_pkg::result_t     result_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_s1 <= item.command;
			col_s1     <= item.col;
			row_s1     <= item.row;
			depth_s1   <= DEPTH_BITS'(item.depth_in);
		end
	end

	assign col_ok = !col_s1[dbtu_pkg::COORD_W-1]
		&& ({1'b0, col_s1} < CmpW'(cfg.frame_width))
		&& ({1'b0, col_s1} < CmpW'(MAX_WIDTH));
	assign row_ok = !row_s1[dbtu_pkg::COORD_W-1]
		&& ({1'b0, row_s1} < CmpW'(cfg.frame_height))
		&& ({1'b0, row_s1} < CmpW'(MAX_HEIGHT));
	assign in_frame_c = col_ok && row_ok;
	assign addr_c     = AddrW'(row_s1) * Stride + AddrW'(col_s1);

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			stored_s2   <= mem[addr_c];
			addr_s2     <= addr_c;
			in_frame_s2 <= in_frame_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AddrW'(1);
		end
	end

	assign status.clear_last = (clr_q == LastAddr);

	assign test_ok   = (command_s1 == dbtu_pkg::CMD_TEST) && (stored_s2 >= depth_s1);
	assign is_write  = (command_s1 == dbtu_pkg::CMD_WRITE);
	assign store_new = in_frame_s2 && (test_ok || is_write);
	assign wr_en     = cmd.clear || (cmd.update && store_new);
	assign wr_addr   = cmd.clear ? clr_q : addr_s2;
	assign wr_data   = cmd.clear ? FarDepth : depth_s1;
	assign depth_after = store_new ? depth_s1 : stored_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.passed    <= in_frame_s2 && test_ok;
			result_q.in_frame  <= in_frame_s2;
			result_q.depth_out <= in_frame_s2 ? dbtu_pkg::DEPTH_W'(depth_after) : '0;
		end
	end

	assign result = result_q;

endmodule

// ===== design/depth_buffer_test_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_buffer_test_update
// Z-buffer with a less-or-equal depth test, plus direct read and write.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to far depth, one entry per
// cycle, over all MAX_WIDTH * MAX_HEIGHT entries (65536 by default), with
// busy high; APB writes are taken during the sweep. Each command beat then
// passes three steps from accept to result: registering the beat, the
// registered memory read, and the compare and write-back through the
// single store port. The result strobe result_valid is high for exactly
// one cycle, in the cycle where busy drops, and cannot be held off, so
// capture result then. A new beat may be started in that same cycle.
// ----------------------------------------------------------------------------
`include "depth_buffer_test_update_defines.svh"

module depth_buffer_test_update #(
	parameter int unsigned MAX_WIDTH  = dbtu_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = dbtu_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned DEPTH_BITS = dbtu_pkg::DEPTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  dbtu_pkg::in_item_t              item,
	output logic                            result_valid,
	output dbtu_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dbtu_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dbtu_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dbtu_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	dbtu_pkg::cfg_t       cfg;
	dbtu_pkg::dp_cmd_t    dp_cmd;
	dbtu_pkg::dp_status_t dp_status;

	dbtu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbtu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.status       (dp_status),
		.cmd          (dp_cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	dbtu_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DEPTH_BITS (DEPTH_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.status (dp_status),
		.item   (item),
		.cfg    (cfg),
		.result (result)
	);

	`DBTU_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(dp_cmd))
	`DBTU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid)
	`DBTU_ASSERT_SAME(a_result_after_accept, result_valid, $past(start && !busy, 3))
	`DBTU_ASSERT_SAME(a_result_idle, result_valid, !busy && !dp_cmd.clear)

endmodule

// ===== bench/depth_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_test_checker
// Watches the command, result and APB channels of the depth buffer. It keeps
// its own copy of the frame registers and of the depth store, predicts the
// result of every accepted beat and compares each result strobe, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module depth_test_checker
	import dbtu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  in_item_t              item,
	input  logic                  result_valid,
	input  result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    fail_count,
	output int                    pending,
	output int                    beat_count,
	output int                    pass_count,
	output int                    outside_count
);

	localparam int unsigned STORE_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

	logic [DEPTH_W-1:0] depth_store [STORE_WORDS];
	logic [FRAME_W-1:0] frame_w;
	logic [FRAME_W-1:0] frame_h;
	result_t            depth_results_q[$];
	result_t            wanted;
	result_t            predicted;

	initial begin
		foreach (depth_store[k]) depth_store[k] = '1;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want_v);
		$display("[%0t] depth buffer mismatch, %s: got 0x%0h, want 0x%0h",
			$time, what, got, want_v);
		fail_count++;
	endtask

	function automatic result_t predict_fragment(in_item_t it);
		result_t     r;
		int          c;
		int          rw;
		int          w;
		int          h;
		int unsigned a;
		r  = '0;
		c  = $signed(it.col);
		rw = $signed(it.row);
		w  = (frame_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_w);
		h  = (frame_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(frame_h);
		if (c >= 0 && rw >= 0 && c < w && rw < h) begin
			a = rw * MAX_WIDTH_DEF + c;
			r.in_frame = 1'b1;
			if (it.command == CMD_TEST) begin
				if (depth_store[a] >= it.depth_in) begin
					depth_store[a] = it.depth_in;
					r.passed = 1'b1;
				end
			end else if (it.command == CMD_WRITE) begin
				depth_store[a] = it.depth_in;
			end
			r.depth_out = depth_store[a];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w       = FRAME_RESET;
			frame_h       = FRAME_RESET;
			fail_count    = 0;
			pending       = 0;
			beat_count    = 0;
			pass_count    = 0;
			outside_count = 0;
		end else begin
			if (result_valid) begin
				if (depth_results_q.size() == 0) begin
					report_mismatch("result with nothing pending", result, 0);
				end else begin
					wanted = depth_results_q.pop_front();
					if (result.passed !== wanted.passed)
						report_mismatch("passed", result.passed, wanted.passed);
					if (result.in_frame !== wanted.in_frame)
						report_mismatch("in_frame", result.in_frame, wanted.in_frame);
					if (result.depth_out !== wanted.depth_out)
						report_mismatch("depth_out", result.depth_out, wanted.depth_out);
				end
			end
			if (start && !busy) begin
				predicted = predict_fragment(item);
				depth_results_q.push_back(predicted);
				beat_count++;
				if (predicted.passed)
					pass_count++;
				if (!predicted.in_frame)
					outside_count++;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_FRAME_WIDTH, 2'b00})
					frame_w = pwdata[FRAME_W-1:0];
				else if (paddr == {REG_FRAME_HEIGHT, 2'b00})
					frame_h = pwdata[FRAME_W-1:0];
			end
			pending = depth_results_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top of the depth buffer. It drives directed fragments covering
// the depth-test corners, the frame edges and every command, then random
// fragments over a series of frame settings, with random gaps on the command
// side and the checker beside the block judging every result.
// ----------------------------------------------------------------------------
module tb;
	import dbtu_pkg::*;

	localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
	localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;
	localparam int IDLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int PHASES        = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	in_item_t              item;
	logic                  result_valid;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int pending;
	int beat_count;
	int pass_count;
	int outside_count;

	int frame_cols;
	int frame_rows;
	int settings_done;
	bit no_idle;
	int idle_cycles;

	int phase_w [PHASES] = '{256, 1, 511, 0, 256, 9, 300, 5, 0, 0};
	int phase_h [PHASES] = '{256, 1, 511, 256, 0, 300, 7, 256, 0, 0};

	depth_buffer_test_update u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	depth_test_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result_valid  (result_valid),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending       (pending),
		.beat_count    (beat_count),
		.pass_count    (pass_count),
		.outside_count (outside_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results pending",
					idle_cycles, pending);
				$display("** depth_buffer_test_update: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue_fragment(logic [CMD_W-1:0] cmd, int c, int r, logic [DEPTH_W-1:0] d);
		in_item_t it;
		it.command  = cmd;
		it.col      = COORD_W'(c);
		it.row      = COORD_W'(r);
		it.depth_in = d;
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic hold_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_frame(int w, int h);
		drain_results();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		frame_cols = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
		frame_rows = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
		settings_done++;
	endtask

	task automatic issue_random_fragment();
		int                 sel;
		int                 c;
		int                 r;
		int                 hw;
		int                 hh;
		logic [CMD_W-1:0]   cmd;
		logic [DEPTH_W-1:0] d;
		sel = $urandom_range(0, 99);
		if (sel < 70 && frame_cols > 0 && frame_rows > 0) begin
			hw = (frame_cols < 4) ? frame_cols : 4;
			hh = (frame_rows < 4) ? frame_rows : 4;
			if ($urandom_range(0, 3) == 0) begin
				c = $urandom_range(0, frame_cols - 1);
				r = $urandom_range(0, frame_rows - 1);
			end else begin
				c = $urandom_range(0, hw - 1);
				r = $urandom_range(0, hh - 1);
			end
		end else if (sel < 85) begin
			case ($urandom_range(0, 3))
				0: c = -1;
				1: c = 0;
				2: c = frame_cols - 1;
				default: c = frame_cols;
			endcase
			case ($urandom_range(0, 3))
				0: r = -1;
				1: r = 0;
				2: r = frame_rows - 1;
				default: r = frame_rows;
			endcase
		end else begin
			c = $signed(COORD_W'($urandom));
			r = $signed(COORD_W'($urandom));
		end
		sel = $urandom_range(0, 99);
		if (sel < 60)
			cmd = CMD_TEST;
		else if (sel < 78)
			cmd = CMD_WRITE;
		else if (sel < 94)
			cmd = CMD_READ;
		else
			cmd = CMD_SPARE;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			d = '0;
		else if (sel < 18)
			d = FAR_DEPTH;
		else if (cmd == CMD_WRITE && sel < 60)
			d = FAR_DEPTH - DEPTH_W'($urandom_range(0, 255));
		else
			d = DEPTH_W'($urandom);
		issue_fragment(cmd, c, r, d);
	endtask

	task automatic run_directed();
		issue_fragment(CMD_READ, 0, 0, 24'h123456);
		issue_fragment(CMD_TEST, 0, 0, FAR_DEPTH);
		issue_fragment(CMD_TEST, 0, 0, 24'h800000);
		issue_fragment(CMD_TEST, 0, 0, 24'h800001);
		issue_fragment(CMD_TEST, 0, 0, 24'h800000);
		issue_fragment(CMD_WRITE, 255, 255, 24'h000000);
		issue_fragment(CMD_TEST, 255, 255, 24'h000000);
		issue_fragment(CMD_TEST, 255, 255, 24'h000001);
		issue_fragment(CMD_SPARE, 255, 255, FAR_DEPTH);
		issue_fragment(CMD_TEST, 256, 0, 24'h000000);
		issue_fragment(CMD_TEST, 0, 256, 24'h000000);
		issue_fragment(CMD_TEST, -1, 0, 24'h000000);
		issue_fragment(CMD_WRITE, -2048, 2047, 24'h5A5A5A);
		issue_fragment(CMD_READ, 2047, -2048, FAR_DEPTH);
		issue_fragment(CMD_WRITE, 3, 7, 24'hABCDEF);
		issue_fragment(CMD_READ, 3, 7, 24'h000000);
		issue_fragment(CMD_TEST, 1, 0, 24'h000000);
		set_frame(1, 1);
		issue_fragment(CMD_TEST, 0, 0, 24'h400000);
		issue_fragment(CMD_TEST, 1, 0, 24'h000000);
		issue_fragment(CMD_WRITE, 0, 1, 24'h000000);
		set_frame(0, 1);
		issue_fragment(CMD_TEST, 0, 0, 24'h000000);
		set_frame(511, 511);
		issue_fragment(CMD_TEST, 300, 0, 24'h000000);
		issue_fragment(CMD_READ, 255, 255, FAR_DEPTH);
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		idle_cycles   = 0;
		frame_cols    = FRAME_RESET;
		frame_rows    = FRAME_RESET;
		settings_done = 1;
		no_idle       = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		for (int p = 0; p < PHASES; p++) begin
			if (p >= 8)
				set_frame($urandom_range(1, 256), $urandom_range(1, 256));
			else
				set_frame(phase_w[p], phase_h[p]);
			no_idle = (p == 0) || ($urandom_range(0, 3) == 0);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				issue_random_fragment();
				if ($urandom_range(0, 99) == 0)
					drain_results();
				else if (pick_gap() != 0)
					hold_sender(pick_gap() + 1);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d fragments over %0d frame settings", beat_count, settings_done);
		$display("%0d depth tests passed, %0d fragments fell outside the frame",
			pass_count, outside_count);
		if (fail_count == 0 && pending == 0) begin
			$display("** depth_buffer_test_update: PASSED **");
		end else begin
			$display("** depth_buffer_test_update: FAILED **");
		end
		$finish;
	end

endmodule
